// ===== rtl/bdq_pkg.sv =====
`default_nettype none
package bdq_pkg;

  localparam int DATA_W        = 32;
  localparam int POS_W         = 4;
  localparam int CNT_W         = 5;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 48;
  localparam int DEFAULT_DEPTH = 16;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd4;
  localparam logic [OP_W-1:0] OP_READ       = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  localparam logic [1:0] CMD_HOLD  = 2'd0;
  localparam logic [1:0] CMD_SHR   = 2'd1;  // toward higher index
  localparam logic [1:0] CMD_SHL   = 2'd2;  // toward lower index
  localparam logic [1:0] CMD_WRITE = 2'd3;

  typedef struct packed {
    logic [1:0]        code;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic              find;
    logic [DATA_W-1:0] key;
  } scan_t;

  typedef struct packed {
    logic              valid;
    logic              done;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  idx;
  } tok_t;

endpackage
`default_nettype wire

// ===== rtl/bounded_deque_with_search.sv =====
`default_nettype none
// Ordered store of up to DEPTH signed 32-bit words kept in a row of cells, index 0 at
// the front. Pushes at either end and pop front update the cells as the beat is taken;
// their result beat is presented on the next cycle. Pop back, find and read send a token
// down the cell row, one cell per clock, and the result is registered once the token
// leaves the last cell. One operation is in flight at a time. Status on out_tuser: ok,
// pop on empty, push on full, or not found / index beyond count. found_position keeps
// the low four bits of the index.
module bounded_deque_with_search #(
  parameter int DEPTH = bdq_pkg::DEFAULT_DEPTH
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [bdq_pkg::OP_W-1:0]         in_tuser,   // operation
  input  wire  [bdq_pkg::IN_TDATA_W-1:0]   in_tdata,   // value[31:0], position[35:32]
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [bdq_pkg::STATUS_W-1:0]     out_tuser,  // status
  output logic [bdq_pkg::OUT_TDATA_W-1:0]  out_tdata   // data[31:0], found_position[35:32],
                                                       // count[40:36]
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bdq_pkg::cmd_t              cmd;
  bdq_pkg::scan_t             scan;
  bdq_pkg::tok_t              tok_src;
  logic [IW-1:0]              wr_target;
  logic [IW-1:0]              scan_target;
  logic [CW-1:0]              occ;
  logic [bdq_pkg::DATA_W-1:0] data_w [DEPTH];
  bdq_pkg::tok_t              tok_w  [DEPTH];

  bdq_ctrl #(
    .DEPTH(DEPTH),
    .IW   (IW),
    .CW   (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .front_data (data_w[0]),
    .tok_end    (tok_w[DEPTH-1]),
    .cmd        (cmd),
    .wr_target  (wr_target),
    .scan       (scan),
    .scan_target(scan_target),
    .occ        (occ),
    .tok_src    (tok_src)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [bdq_pkg::DATA_W-1:0] left_d, right_d;
    bdq_pkg::tok_t              tin;

    if (i == 0) begin : g_first
      assign left_d = cmd.value;
      assign tin    = tok_src;
    end else begin : g_mid
      assign left_d = data_w[i-1];
      assign tin    = tok_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = data_w[i+1];
    end

    bdq_cell #(
      .IDX(i),
      .IW (IW),
      .CW (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .wr_target  (wr_target),
      .left_data  (left_d),
      .right_data (right_d),
      .scan       (scan),
      .scan_target(scan_target),
      .occ        (occ),
      .tok_in     (tin),
      .tok_out    (tok_w[i]),
      .data_out   (data_w[i])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/bdq_cell.sv =====
`default_nettype none
module bdq_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int CW  = 5
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  bdq_pkg::cmd_t                cmd,
  input  wire  [IW-1:0]                wr_target,
  input  wire  [bdq_pkg::DATA_W-1:0]   left_data,
  input  wire  [bdq_pkg::DATA_W-1:0]   right_data,
  input  bdq_pkg::scan_t               scan,
  input  wire  [IW-1:0]                scan_target,
  input  wire  [CW-1:0]                occ,
  input  bdq_pkg::tok_t                tok_in,
  output bdq_pkg::tok_t                tok_out,
  output logic [bdq_pkg::DATA_W-1:0]   data_out
);

  logic [bdq_pkg::DATA_W-1:0] data_r, data_nxt;
  bdq_pkg::tok_t              tok_r, tok_nxt;
  logic                       hit;

  always_comb begin
    case (cmd.code)
      bdq_pkg::CMD_SHR:   data_nxt = left_data;
      bdq_pkg::CMD_SHL:   data_nxt = right_data;
      bdq_pkg::CMD_WRITE: data_nxt = (IW'(IDX) == wr_target) ? cmd.value : data_r;
      default:            data_nxt = data_r;
    endcase
  end

  // The first live cell that matches claims the passing token; later cells only forward it.
  assign hit = scan.find ? ((data_r == scan.key) && (CW'(IDX) < occ))
                         : (IW'(IDX) == scan_target);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.done && hit) begin
      tok_nxt.done = 1'b1;
      tok_nxt.data = data_r;
      tok_nxt.idx  = bdq_pkg::POS_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out  = tok_r;
  assign data_out = data_r;

endmodule
`default_nettype wire

// ===== rtl/bdq_ctrl.sv =====
`default_nettype none
module bdq_ctrl #(
  parameter int DEPTH = bdq_pkg::DEFAULT_DEPTH,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [bdq_pkg::OP_W-1:0]          in_tuser,
  input  wire  [bdq_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [bdq_pkg::STATUS_W-1:0]      out_tuser,
  output logic [bdq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire  [bdq_pkg::DATA_W-1:0]        front_data,
  input  bdq_pkg::tok_t                     tok_end,
  output bdq_pkg::cmd_t                     cmd,
  output logic [IW-1:0]                     wr_target,
  output bdq_pkg::scan_t                    scan,
  output logic [IW-1:0]                     scan_target,
  output logic [CW-1:0]                     occ,
  output bdq_pkg::tok_t                     tok_src
);

  logic                          acc;
  logic [bdq_pkg::OP_W-1:0]      op;
  logic [bdq_pkg::DATA_W-1:0]    val;
  logic [bdq_pkg::POS_W-1:0]     pos;
  logic                          full, empty;

  logic [CW-1:0]                 occ_r, occ_nxt;
  logic                          busy_r, busy_nxt;
  logic                          pop_r, pop_nxt;
  logic                          find_r, find_nxt;
  logic [bdq_pkg::DATA_W-1:0]    key_r, key_nxt;
  logic [IW-1:0]                 target_r, target_nxt;
  bdq_pkg::tok_t                 tok_src_r, tok_src_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bdq_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [bdq_pkg::DATA_W-1:0]    out_data_r, out_data_nxt;
  logic [bdq_pkg::POS_W-1:0]     out_fpos_r, out_fpos_nxt;
  logic [bdq_pkg::CNT_W-1:0]     out_count_r, out_count_nxt;

  assign op    = in_tuser;
  assign val   = in_tdata[bdq_pkg::DATA_W-1:0];
  assign pos   = in_tdata[bdq_pkg::DATA_W +: bdq_pkg::POS_W];
  assign full  = (occ_r == CW'(DEPTH));
  assign empty = (occ_r == '0);

  assign in_tready = !busy_r && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    occ_nxt        = occ_r;
    busy_nxt       = busy_r;
    pop_nxt        = pop_r;
    find_nxt       = find_r;
    key_nxt        = key_r;
    target_nxt     = target_r;
    tok_src_nxt    = '0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_fpos_nxt   = out_fpos_r;
    out_count_nxt  = out_count_r;
    cmd.code       = bdq_pkg::CMD_HOLD;
    cmd.value      = val;

    if (acc) begin
      out_status_nxt = bdq_pkg::ST_OK;
      out_data_nxt   = '0;
      out_fpos_nxt   = '0;
      out_count_nxt  = bdq_pkg::CNT_W'(occ_r);
      out_valid_nxt  = 1'b1;
      case (op)
        bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            out_status_nxt = bdq_pkg::ST_FULL;
          end else begin
            cmd.code      = (op == bdq_pkg::OP_PUSH_FRONT) ? bdq_pkg::CMD_SHR
                                                           : bdq_pkg::CMD_WRITE;
            occ_nxt       = occ_r + CW'(1);
            out_count_nxt = bdq_pkg::CNT_W'(occ_r + CW'(1));
          end
        end
        bdq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            out_status_nxt = bdq_pkg::ST_EMPTY;
          end else begin
            cmd.code      = bdq_pkg::CMD_SHL;
            out_data_nxt  = front_data;
            occ_nxt       = occ_r - CW'(1);
            out_count_nxt = bdq_pkg::CNT_W'(occ_r - CW'(1));
          end
        end
        bdq_pkg::OP_POP_BACK: begin
          if (empty) begin
            out_status_nxt = bdq_pkg::ST_EMPTY;
          end else begin
            out_valid_nxt     = 1'b0;
            busy_nxt          = 1'b1;
            pop_nxt           = 1'b1;
            find_nxt          = 1'b0;
            target_nxt        = IW'(occ_r - CW'(1));
            tok_src_nxt.valid = 1'b1;
          end
        end
        bdq_pkg::OP_FIND: begin
          if (empty) begin
            out_status_nxt = bdq_pkg::ST_MISS;
          end else begin
            out_valid_nxt     = 1'b0;
            busy_nxt          = 1'b1;
            pop_nxt           = 1'b0;
            find_nxt          = 1'b1;
            key_nxt           = val;
            tok_src_nxt.valid = 1'b1;
          end
        end
        bdq_pkg::OP_READ: begin
          if (int'(pos) < int'(occ_r)) begin
            out_valid_nxt     = 1'b0;
            busy_nxt          = 1'b1;
            pop_nxt           = 1'b0;
            find_nxt          = 1'b0;
            target_nxt        = IW'(pos);
            tok_src_nxt.valid = 1'b1;
          end else begin
            out_status_nxt = bdq_pkg::ST_MISS;
          end
        end
        default: begin
        end
      endcase
    end

    // The token has walked the whole row; its payload is the lookup result.
    if (tok_end.valid) begin
      busy_nxt       = 1'b0;
      out_valid_nxt  = 1'b1;
      out_status_nxt = tok_end.done ? bdq_pkg::ST_OK : bdq_pkg::ST_MISS;
      out_data_nxt   = (tok_end.done && !find_r) ? tok_end.data : '0;
      out_fpos_nxt   = (tok_end.done && find_r) ? tok_end.idx : '0;
      out_count_nxt  = bdq_pkg::CNT_W'(occ_r);
      if (pop_r) begin
        occ_nxt       = occ_r - CW'(1);
        out_count_nxt = bdq_pkg::CNT_W'(occ_r - CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    pop_r        <= pop_nxt;
    find_r       <= find_nxt;
    key_r        <= key_nxt;
    target_r     <= target_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_count_r  <= out_count_nxt;
    if (!rst_n) begin
      occ_r       <= '0;
      busy_r      <= 1'b0;
      tok_src_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      busy_r      <= busy_nxt;
      tok_src_r   <= tok_src_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign wr_target   = occ_r[IW-1:0];
  assign scan        = '{find: find_r, key: key_r};
  assign scan_target = target_r;
  assign occ         = occ_r;
  assign tok_src     = tok_src_r;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(bdq_pkg::OUT_TDATA_W - bdq_pkg::DATA_W - bdq_pkg::POS_W
                        - bdq_pkg::CNT_W){1'b0}},
                       out_count_r, out_fpos_r, out_data_r};

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_tok_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.valid |-> busy_r)
    else $error("token left the row while no lookup was running");

  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !out_valid_r)
    else $error("result pending during a lookup");

  a_pop_front_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == bdq_pkg::OP_POP_FRONT && !empty) |=> occ_r == $past(occ_r) - CW'(1))
    else $error("pop front did not lower the count");
`endif

endmodule
`default_nettype wire
